// File: hw/rtl/ntd_pkg.sv
// ntd_pkg: shared types and constants of the number-to-digit-text formatter
// used by the channel interfaces, the front, the queue and the back end
package ntd_pkg;

  localparam int VALUE_W   = 32;
  localparam int CNT_W     = 6;
  localparam int LINE_W    = 4;
  localparam int COL_W     = 8;
  localparam int CHAR_W    = 7;

  localparam int NUM_BCD   = 10;
  localparam int BCD_W     = 4 * NUM_BCD;
  localparam int STEP_W    = $clog2(VALUE_W);

  // queue depth, a power of two
  localparam int QDEPTH    = 2;
  localparam int QAW       = $clog2(QDEPTH);

  localparam logic [CNT_W-1:0] MAX_DEC = CNT_W'(10);
  localparam logic [CNT_W-1:0] MAX_HEX = CNT_W'(8);
  localparam logic [CNT_W-1:0] MAX_BIN = CNT_W'(32);

  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CH_ALPHA = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CH_PLUS  = CHAR_W'(8'h2B);
  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(8'h2D);

  typedef enum logic [1:0] {
    KIND_UDEC = 2'd0,
    KIND_SDEC = 2'd1,
    KIND_HEX  = 2'd2,
    KIND_BIN  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } bk_state_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] mag;
    logic [CNT_W-1:0]   cnt;
    logic               neg;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
  } desc_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QAW:0]   count;
  } q_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_ALPHA + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/ntd_if.sv
// ntd_in_if / ntd_out_if: valid-ready channels of the formatter
// depends on ntd_pkg for field widths and the kind type
interface ntd_in_if;
  logic                         valid;
  logic                         ready;
  ntd_pkg::kind_t               kind;
  logic [ntd_pkg::VALUE_W-1:0]  value;
  logic [ntd_pkg::CNT_W-1:0]    digit_count;
  logic [ntd_pkg::LINE_W-1:0]   line;
  logic [ntd_pkg::COL_W-1:0]    start_column;

  modport source (output valid, kind, value, digit_count, line, start_column,
                  input ready);
  modport sink   (input valid, kind, value, digit_count, line, start_column,
                  output ready);
endinterface

interface ntd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ntd_pkg::CHAR_W-1:0]   char_code;
  logic [ntd_pkg::LINE_W-1:0]   line_out;
  logic [ntd_pkg::COL_W-1:0]    column;
  logic                         last;

  modport source (output valid, char_code, line_out, column, last,
                  input ready);
  modport sink   (input valid, char_code, line_out, column, last,
                  output ready);
endinterface

// File: hw/rtl/number_to_digit_text_core.sv
// number_to_digit_text_core: binary to ascii decimal / hex / binary formatter
// depends on ntd_pkg, ntd_if, ntd_front, ntd_fifo and ntd_back
//
// in_ch carries one number per beat: kind, value, digit_count, line and
// start_column. out_ch carries one character per beat, most significant
// first, with line_out, column (start plus index, wrapping at 256) and last
// on the final character. Unsigned modes with a zero count produce no beat.
// The front takes an input beat whenever the two-entry queue has room, so
// it keeps accepting while the back end is busy or the receiver stalls.
// The back end pops one item at a time. Decimal items run a double-dabble
// conversion, one bit per cycle; hex and binary skip it. Characters then
// leave at one per cycle, while the receiver takes them, through a single
// output register. An item carries at most 32 characters in binary and 11
// in signed decimal. The back end pops the next item only once the last
// character of the current one has been emitted.
// A stalled receiver holds the output beat and freezes emission.
// rst_n is synchronous, active low; it empties the queue and the output.
module number_to_digit_text_core (
  input  logic       clk,
  input  logic       rst_n,
  ntd_in_if.sink     in_ch,
  ntd_out_if.source  out_ch
);
  import ntd_pkg::*;

  logic      q_push;
  logic      q_pop;
  desc_t     q_wdata;
  desc_t     q_rdata;
  q_status_t q_status;

  ntd_front u_front (
    .in_ch  (in_ch),
    .q_full (q_status.full),
    .push   (q_push),
    .desc   (q_wdata)
  );

  ntd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  ntd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .desc    (q_rdata),
    .q_empty (q_status.empty),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("queue pop while empty");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> !q_status.empty)
    else $error("pushed item missing from queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// File: hw/rtl/ntd_fifo.sv
// ntd_fifo: short descriptor queue between front and back
// depends on ntd_pkg for desc_t, q_status_t and the depth
module ntd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ntd_pkg::desc_t     wdata,
  input  logic               pop,
  output ntd_pkg::desc_t     rdata,
  output ntd_pkg::q_status_t status
);
  import ntd_pkg::*;

  desc_t          mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r;
  logic [QAW-1:0] rptr_r;
  logic [QAW:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign rdata        = mem_r[rptr_r];
  assign status.full  = (count_r == (QAW+1)'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign status.count = count_r;

endmodule

// File: hw/rtl/ntd_front.sv
// ntd_front: accepts input beats, saturates the count, takes the magnitude
// depends on ntd_pkg and ntd_in_if; feeds ntd_fifo
module ntd_front (
  ntd_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output ntd_pkg::desc_t  desc
);
  import ntd_pkg::*;

  logic [CNT_W-1:0] maxd;
  logic [CNT_W-1:0] cnt_sat;
  logic             neg;

  always_comb begin
    case (in_ch.kind)
      KIND_HEX: maxd = MAX_HEX;
      KIND_BIN: maxd = MAX_BIN;
      default:  maxd = MAX_DEC;
    endcase
  end

  assign cnt_sat = (in_ch.digit_count > maxd) ? maxd : in_ch.digit_count;
  assign neg     = (in_ch.kind == KIND_SDEC) && in_ch.value[VALUE_W-1];

  assign in_ch.ready = !q_full;

  // unsigned modes with a zero count produce nothing and are dropped here
  assign push = in_ch.valid && !q_full &&
                ((in_ch.kind == KIND_SDEC) || (cnt_sat != '0));

  assign desc.kind = in_ch.kind;
  assign desc.mag  = neg ? (~in_ch.value + 1'b1) : in_ch.value;
  assign desc.cnt  = cnt_sat;
  assign desc.neg  = neg;
  assign desc.line = in_ch.line;
  assign desc.col  = in_ch.start_column;

endmodule

// File: hw/rtl/ntd_back.sv
// ntd_back: converts one descriptor and emits its characters one per beat
// depends on ntd_pkg and ntd_out_if; reads from ntd_fifo
module ntd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ntd_pkg::desc_t     desc,
  input  logic               q_empty,
  output logic               pop,
  ntd_out_if.source          out_ch
);
  import ntd_pkg::*;

  bk_state_t          state_r, state_nxt;
  desc_t              cur_r;
  logic [VALUE_W-1:0] bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   rem_r;
  logic               sign_r;
  logic [COL_W-1:0]   col_r;

  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [LINE_W-1:0]  out_line_r;
  logic [COL_W-1:0]   out_col_r;
  logic               out_last_r;

  logic               slot_free;
  logic               emit;
  logic               emit_last;
  logic [CHAR_W-1:0]  emit_char;
  logic [CNT_W-1:0]   idx;
  logic [3:0]         dig;
  logic [BCD_W-1:0]   bcd_adj;
  logic               is_dec;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign is_dec    = (desc.kind == KIND_UDEC) || (desc.kind == KIND_SDEC);
  assign idx       = rem_r - 1'b1;

  // add-3 on every bcd digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_BCD; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    case (cur_r.kind)
      KIND_HEX: dig = cur_r.mag[{idx[2:0], 2'b00} +: 4];
      KIND_BIN: dig = {3'b000, cur_r.mag[idx[STEP_W-1:0]]};
      default:  dig = bcd_r[{idx[3:0], 2'b00} +: 4];
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    emit_char = digit_char(dig);
    emit_last = (rem_r == CNT_W'(1));
    case (state_r)
      BK_IDLE: begin
        pop = !q_empty;
      end
      BK_EMIT: begin
        emit = slot_free;
        if (sign_r) begin
          emit_char = cur_r.neg ? CH_MINUS : CH_PLUS;
          emit_last = (rem_r == '0);
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = is_dec ? BK_CONV : BK_EMIT;
        end
      end
      BK_CONV: begin
        if (step_r == STEP_W'(VALUE_W - 1)) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (emit && emit_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= desc;
      bin_r  <= desc.mag;
      bcd_r  <= '0;
      step_r <= '0;
      rem_r  <= desc.cnt;
      sign_r <= (desc.kind == KIND_SDEC);
      col_r  <= desc.col;
    end
    if (state_r == BK_CONV) begin
      bcd_r  <= {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      bin_r  <= {bin_r[VALUE_W-2:0], 1'b0};
      step_r <= step_r + 1'b1;
    end
    if (emit) begin
      out_char_r <= emit_char;
      out_line_r <= cur_r.line;
      out_col_r  <= col_r;
      out_last_r <= emit_last;
      col_r      <= col_r + 1'b1;
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        rem_r <= rem_r - 1'b1;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.line_out  = out_line_r;
  assign out_ch.column    = out_col_r;
  assign out_ch.last      = out_last_r;

endmodule

// File: tb/ntd_checker.sv
`timescale 1ns / 1ps
// ntd_checker: watches both channels of the number-to-text formatter, predicts
// the characters of every accepted number and compares them beat by beat
// depends on ntd_pkg and the channel interfaces in ntd_if
module ntd_checker (
  input  logic clk,
  input  logic rst_n,
  ntd_in_if    in_mon,
  ntd_out_if   out_mon,
  output int   fail_count,
  output int   chars_waiting,
  output int   beats_checked
);
  import ntd_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] char_code;
    logic [LINE_W-1:0] line_out;
    logic [COL_W-1:0]  column;
    logic              last;
  } text_beat_t;

  text_beat_t expected_text[$];
  int         mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // expands one number into its characters, most significant first
  task automatic predict_text(input kind_t kind, input logic [VALUE_W-1:0] value,
                              input logic [CNT_W-1:0] count,
                              input logic [LINE_W-1:0] line,
                              input logic [COL_W-1:0] col);
    int unsigned        base;
    int unsigned        max_digits;
    int unsigned        digits;
    int unsigned        total;
    int unsigned        n;
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digs[32];
    logic               negative;
    text_beat_t         b;
    case (kind)
      KIND_HEX: begin
        base = 16;
        max_digits = 8;
      end
      KIND_BIN: begin
        base = 2;
        max_digits = 32;
      end
      default: begin
        base = 10;
        max_digits = 10;
      end
    endcase
    digits = (count > max_digits) ? max_digits : count;
    mag = value;
    n = 0;
    if (kind == KIND_SDEC) begin
      negative = value[VALUE_W-1];
      if (negative) mag = ~value + 1'b1;
      total = digits + 1;
      b.char_code = negative ? CH_MINUS : CH_PLUS;
      b.line_out  = line;
      b.column    = col;
      b.last      = (total == 1);
      expected_text.push_back(b);
      n = 1;
    end else begin
      total = digits;
    end
    for (int i = 0; i < digits; i++) begin
      digs[i] = 4'(mag % base);
      mag = mag / base;
    end
    for (int i = 0; i < digits; i++) begin
      b.char_code = (digs[digits-1-i] < 10) ? CH_ZERO + CHAR_W'(digs[digits-1-i])
                                            : CH_ALPHA + CHAR_W'(digs[digits-1-i] - 10);
      b.line_out  = line;
      b.column    = col + COL_W'(n);
      b.last      = (n + 1 == total);
      expected_text.push_back(b);
      n++;
    end
  endtask

  always @(posedge clk) begin
    text_beat_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        predict_text(in_mon.kind, in_mon.value, in_mon.digit_count, in_mon.line,
                     in_mon.start_column);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected beat, char", out_mon.char_code, 0);
        end else begin
          want = expected_text.pop_front();
          if (out_mon.char_code !== want.char_code)
            report_mismatch("char_code", out_mon.char_code, want.char_code);
          if (out_mon.line_out !== want.line_out)
            report_mismatch("line_out", out_mon.line_out, want.line_out);
          if (out_mon.column !== want.column)
            report_mismatch("column", out_mon.column, want.column);
          if (out_mon.last !== want.last)
            report_mismatch("last", out_mon.last, want.last);
        end
        beats_checked <= beats_checked + 1;
      end
    end
    chars_waiting <= expected_text.size();
  end

endmodule

// File: tb/tb_number_to_digit_text_core.sv
`timescale 1ns / 1ps
// tb_number_to_digit_text_core: drives numbers of every mode into the formatter,
// stalls the character side at random and gives the verdict from ntd_checker
// depends on ntd_pkg, ntd_if, number_to_digit_text_core and ntd_checker
module tb_number_to_digit_text_core;
  import ntd_pkg::*;

  localparam int RANDOM_ITEMS = 310;
  localparam int STEADY_ITEMS = 60;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ntd_in_if  in_ch();
  ntd_out_if out_ch();

  int fail_count;
  int chars_waiting;
  int beats_checked;
  int numbers_sent = 0;
  int kind_hist[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  bit steady_flow = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  number_to_digit_text_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ntd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .chars_waiting (chars_waiting),
    .beats_checked (beats_checked)
  );

  // offers one number after a random gap (none while steady_flow is set) and waits for its beat
  task automatic send_number(input kind_t kind, input logic [VALUE_W-1:0] value,
                             input logic [CNT_W-1:0] count,
                             input logic [LINE_W-1:0] line,
                             input logic [COL_W-1:0] col);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.value        <= value;
    in_ch.digit_count  <= count;
    in_ch.line         <= line;
    in_ch.start_column <= col;
    do @(posedge clk); while (!in_ch.ready);
    numbers_sent++;
    kind_hist[kind]++;
  endtask

  task automatic send_random_number();
    kind_t              kind;
    int unsigned        max_digits;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   count;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
    kind = kind_t'(2'($urandom_range(0, 3)));
    max_digits = (kind == KIND_HEX) ? 8 : (kind == KIND_BIN) ? 32 : 10;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: value = 32'h0000_0000;
          1: value = 32'hFFFF_FFFF;
          2: value = 32'h8000_0000;
          default: value = 32'h7FFF_FFFF;
        endcase
      end
      1: value = $urandom_range(0, 999);
      default: value = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0: count = '0;
      1: count = CNT_W'($urandom_range(0, 63));
      default: count = CNT_W'($urandom_range(1, max_digits));
    endcase
    line = ($urandom_range(0, 7) == 0) ? LINE_W'($urandom_range(0, 15))
                                       : LINE_W'($urandom_range(1, 8));
    col  = ($urandom_range(0, 3) == 0) ? COL_W'($urandom_range(230, 255))
                                       : COL_W'($urandom_range(0, 255));
    send_number(kind, value, count, line, col);
  endtask

  // receiver: random ready gaps, with long hold-offs to back the block up
  initial begin
    int gap;
    int taken;
    taken = 0;
    out_ch.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if (taken == 120 || taken == 2500) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any beat on either channel
  initial begin
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d characters outstanding",
                 idle_cycles, chars_waiting);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_UDEC;
    in_ch.value        = '0;
    in_ch.digit_count  = '0;
    in_ch.line         = '0;
    in_ch.start_column = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, truncation, saturation, zero counts, wrap
    send_number(KIND_UDEC, 32'h0000_0000, 6'd10, 4'd1, 8'd0);
    send_number(KIND_UDEC, 32'hFFFF_FFFF, 6'd10, 4'd8, 8'd10);
    send_number(KIND_UDEC, 32'd12345, 6'd3, 4'd2, 8'd20);
    send_number(KIND_UDEC, 32'd777, 6'd0, 4'd3, 8'd30);
    send_number(KIND_UDEC, 32'd4000000000, 6'd63, 4'd4, 8'd40);
    send_number(KIND_SDEC, 32'h0000_0000, 6'd10, 4'd5, 8'd50);
    send_number(KIND_SDEC, 32'h8000_0000, 6'd10, 4'd6, 8'd60);
    send_number(KIND_SDEC, 32'h7FFF_FFFF, 6'd12, 4'd7, 8'd70);
    send_number(KIND_SDEC, 32'hFFFF_FFFF, 6'd1, 4'd8, 8'd80);
    send_number(KIND_SDEC, 32'hFFFF_FF00, 6'd0, 4'd1, 8'd90);
    send_number(KIND_SDEC, 32'd42, 6'd0, 4'd2, 8'd255);
    send_number(KIND_HEX, 32'hDEAD_BEEF, 6'd8, 4'd3, 8'd100);
    send_number(KIND_HEX, 32'hFFFF_FFFF, 6'd9, 4'd4, 8'd110);
    send_number(KIND_HEX, 32'hABCD_EF01, 6'd0, 4'd5, 8'd120);
    send_number(KIND_HEX, 32'h0000_0000, 6'd3, 4'd6, 8'd130);
    send_number(KIND_BIN, 32'hAAAA_AAAA, 6'd32, 4'd7, 8'd140);
    send_number(KIND_BIN, 32'h5555_5555, 6'd40, 4'd8, 8'd150);
    send_number(KIND_BIN, 32'hFFFF_FFFF, 6'd63, 4'd1, 8'd160);
    send_number(KIND_BIN, 32'd5, 6'd0, 4'd2, 8'd170);
    send_number(KIND_BIN, 32'h8000_0001, 6'd32, 4'd3, 8'd250);
    send_number(KIND_SDEC, 32'h8000_0000, 6'd10, 4'd4, 8'd251);
    send_number(KIND_HEX, 32'h1234_5678, 6'd8, 4'd15, 8'd252);
    send_number(KIND_UDEC, 32'd9, 6'd2, 4'd0, 8'd255);

    // let everything drain before the random part
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (chars_waiting == 0);
    @(posedge clk);

    steady_flow = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == STEADY_ITEMS) steady_flow = 1'b0;
      send_random_number();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (chars_waiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d numbers (udec %0d, sdec %0d, hex %0d, bin %0d), checked %0d chars",
             numbers_sent, kind_hist[KIND_UDEC], kind_hist[KIND_SDEC],
             kind_hist[KIND_HEX], kind_hist[KIND_BIN], beats_checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
